[sv/crdc_pkg.sv]
// Shared types and fixed widths for the camera ray direction color block.
// No dependencies; imported by every module of the block.
package crdc_pkg;

  localparam int PIX_W      = 12;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int MAG_W      = 13;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int LEN2_W     = SQ_W + 2;
  localparam int LEN_FRAC   = 8;
  localparam int ROOT_W     = (LEN2_W + 2 * LEN_FRAC) / 2;
  localparam int REM_W      = ROOT_W + 4;
  localparam int COLOR_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 13'd1280;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 13'd720;

  typedef struct packed {
    logic [MAG_W-1:0] ma;
    logic [MAG_W-1:0] mb;
    logic [MAG_W-1:0] mh;
  } mag_t;

endpackage

[sv/crdc_front.sv]
// Front stages: screen offsets, their magnitudes, squares and squared length.
// Depends on crdc_pkg.
module crdc_front import crdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [CFG_W-1:0]  width,
  input  logic [CFG_W-1:0]  height,
  input  logic              in_vld,
  output logic              in_rdy,
  input  logic [PIX_W-1:0]  row,
  input  logic [PIX_W-1:0]  col,
  output logic              out_vld,
  input  logic              out_rdy,
  output mag_t              out_mag,
  output logic [LEN2_W-1:0] out_len2
);

  logic [CFG_W-1:0] w_eff, h_eff;
  logic signed [14:0] a_val, b_val;
  logic [14:0] a_neg, b_neg;
  mag_t mag0;

  logic vld1, vld2, vld3;
  logic en1, en2, en3;
  mag_t mag1, mag2, mag3;
  logic [SQ_W-1:0] sq_a, sq_b, sq_h;
  logic [LEN2_W-1:0] len2;

  // a zero resolution counts as one
  assign w_eff = (width == '0) ? CFG_W'(1) : width;
  assign h_eff = (height == '0) ? CFG_W'(1) : height;

  assign a_val = $signed({2'b00, col, 1'b1}) - $signed({2'b00, w_eff});
  assign b_val = $signed({2'b00, h_eff}) - $signed({2'b00, row, 1'b1});
  assign a_neg = -a_val;
  assign b_neg = -b_val;

  assign mag0.ma = a_val[14] ? a_neg[MAG_W-1:0] : a_val[MAG_W-1:0];
  assign mag0.mb = b_val[14] ? b_neg[MAG_W-1:0] : b_val[MAG_W-1:0];
  assign mag0.mh = h_eff;

  assign en3    = !vld3 || out_rdy;
  assign en2    = !vld2 || en3;
  assign en1    = !vld1 || en2;
  assign in_rdy = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      if (en1) vld1 <= in_vld;
      if (en2) vld2 <= vld1;
      if (en3) vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) mag1 <= mag0;
    if (en2) begin
      mag2 <= mag1;
      sq_a <= mag1.ma * mag1.ma;
      sq_b <= mag1.mb * mag1.mb;
      sq_h <= mag1.mh * mag1.mh;
    end
    if (en3) begin
      mag3 <= mag2;
      len2 <= LEN2_W'(sq_a) + LEN2_W'(sq_b) + LEN2_W'(sq_h);
    end
  end

  assign out_vld  = vld3;
  assign out_mag  = mag3;
  assign out_len2 = len2;

endmodule

[sv/crdc_sqrt.sv]
// Pipelined square root of the squared length, one root bit per stage.
// Depends on crdc_pkg.
module crdc_sqrt import crdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  output logic              in_rdy,
  input  mag_t              in_mag,
  input  logic [LEN2_W-1:0] in_len2,
  output logic              out_vld,
  input  logic              out_rdy,
  output mag_t              out_mag,
  output logic [ROOT_W-1:0] out_root
);

  localparam int N = ROOT_W;

  logic              p_vld  [0:N];
  logic              p_rdy  [0:N];
  mag_t              p_mag  [0:N];
  logic [REM_W-1:0]  p_rem  [0:N];
  logic [ROOT_W-1:0] p_root [0:N];
  logic [LEN2_W-1:0] p_rad  [0:N];

  assign p_vld[0]  = in_vld;
  assign p_mag[0]  = in_mag;
  assign p_rem[0]  = '0;
  assign p_root[0] = '0;
  assign p_rad[0]  = in_len2;
  assign p_rdy[N]  = out_rdy;
  assign in_rdy    = p_rdy[0];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic [REM_W-1:0] rem_sh, trial, diff;
      logic ge;

      // bring down the next two radicand bits, then try root*4+1
      assign rem_sh = {p_rem[k][REM_W-3:0], p_rad[k][LEN2_W-1 -: 2]};
      assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, p_root[k], 2'b01};
      assign ge     = rem_sh >= trial;
      assign diff   = rem_sh - trial;
      assign p_rdy[k] = !p_vld[k+1] || p_rdy[k+1];

      always_ff @(posedge clk) begin
        if (rst) begin
          p_vld[k+1] <= 1'b0;
        end else if (p_rdy[k]) begin
          p_vld[k+1] <= p_vld[k];
        end
      end

      always_ff @(posedge clk) begin
        if (p_rdy[k]) begin
          p_mag[k+1]  <= p_mag[k];
          p_rem[k+1]  <= ge ? diff : rem_sh;
          p_root[k+1] <= {p_root[k][ROOT_W-2:0], ge};
          p_rad[k+1]  <= {p_rad[k][LEN2_W-3:0], 2'b00};
        end
      end
    end
  endgenerate

  assign out_vld  = p_vld[N];
  assign out_mag  = p_mag[N];
  assign out_root = p_root[N];

  // the height term alone keeps the length at one or more
  a_root_min: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> out_root >= ROOT_W'(1 << LEN_FRAC))
    else $error("length root below one");

endmodule

[sv/crdc_div.sv]
// Three-lane pipelined restoring divider: each magnitude over the length.
// Depends on crdc_pkg.
module crdc_div import crdc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  output logic                         in_rdy,
  input  mag_t                         in_mag,
  input  logic [ROOT_W-1:0]            in_root,
  output logic                         out_vld,
  input  logic                         out_rdy,
  output logic [2:0][FRAC_BITS:0]      out_q
);

  localparam int Q_W  = FRAC_BITS + 1;
  localparam int DR_W = ROOT_W + 1;

  logic                  p_vld [0:Q_W];
  logic                  p_rdy [0:Q_W];
  logic [ROOT_W-1:0]     p_d   [0:Q_W];
  logic [2:0][DR_W-1:0]  p_rem [0:Q_W];
  logic [2:0][Q_W-1:0]   p_q   [0:Q_W];

  // start from mag*2^(LEN_FRAC-1): below the divisor, so Q_W steps finish it
  assign p_rem[0][0] = {{(DR_W-MAG_W-LEN_FRAC+1){1'b0}}, in_mag.ma, {(LEN_FRAC-1){1'b0}}};
  assign p_rem[0][1] = {{(DR_W-MAG_W-LEN_FRAC+1){1'b0}}, in_mag.mb, {(LEN_FRAC-1){1'b0}}};
  assign p_rem[0][2] = {{(DR_W-MAG_W-LEN_FRAC+1){1'b0}}, in_mag.mh, {(LEN_FRAC-1){1'b0}}};
  assign p_vld[0]    = in_vld;
  assign p_d[0]      = in_root;
  assign p_q[0]      = '0;
  assign p_rdy[Q_W]  = out_rdy;
  assign in_rdy      = p_rdy[0];

  genvar k, j;
  generate
    for (k = 0; k < Q_W; k++) begin : g_stage
      assign p_rdy[k] = !p_vld[k+1] || p_rdy[k+1];

      always_ff @(posedge clk) begin
        if (rst) begin
          p_vld[k+1] <= 1'b0;
        end else if (p_rdy[k]) begin
          p_vld[k+1] <= p_vld[k];
        end
      end

      always_ff @(posedge clk) begin
        if (p_rdy[k]) p_d[k+1] <= p_d[k];
      end

      for (j = 0; j < 3; j++) begin : g_lane
        logic [DR_W:0] t, dext, diff;
        logic ge;

        assign t    = {p_rem[k][j], 1'b0};
        assign dext = {2'b00, p_d[k]};
        assign ge   = t >= dext;
        assign diff = t - dext;

        always_ff @(posedge clk) begin
          if (p_rdy[k]) begin
            p_rem[k+1][j] <= ge ? diff[DR_W-1:0] : t[DR_W-1:0];
            p_q[k+1][j]   <= {p_q[k][j][Q_W-2:0], ge};
          end
        end
      end
    end
  endgenerate

  assign out_vld = p_vld[Q_W];
  assign out_q   = p_q[Q_W];

  a_q_unit: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> (out_q[0] <= (Q_W'(1) << FRAC_BITS)) &&
                (out_q[1] <= (Q_W'(1) << FRAC_BITS)) &&
                (out_q[2] <= (Q_W'(1) << FRAC_BITS)))
    else $error("unit component above one");

endmodule

[sv/camera_ray_direction_color_top.sv]
// Pinhole camera primary ray direction shown as an RGB color.
// Usage:
//   Input channel: pixel_row, pixel_col with in_valid / in_stall.
//   Output channel: red, green, blue with out_valid / out_stall.
//   A transfer happens on a rising edge with valid high and stall low.
//   Config: cfg_write with cfg_index 0 = image width, 1 = image height,
//   13-bit cfg_data; write only while no pixel is in flight.
// The pipeline has 3 front stages, 22 square root stages (one root bit
//   each), FRAC_BITS+1 divider stages (one quotient bit each, three
//   lanes) and one output register.
// Throughput is one pixel per cycle; each pipeline stage holds its own
//   valid bit, so empty stages still fill while the receiver stalls.
//   in_stall rises only when every stage is full and out_stall is high.
// Reset (rst, synchronous) empties the pipeline and sets the resolution
//   to 1280 x 720.
// Depends on crdc_pkg, crdc_front, crdc_sqrt, crdc_div.
module camera_ray_direction_color_top import crdc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     pixel_row,
  input  logic [PIX_W-1:0]     pixel_col,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COLOR_W-1:0]   red,
  output logic [COLOR_W-1:0]   green,
  output logic [COLOR_W-1:0]   blue
);

  localparam int Q_W = FRAC_BITS + 1;
  localparam int P_W = Q_W + COLOR_W;

  logic [CFG_W-1:0] image_width, image_height;

  logic              f_rdy, f_vld;
  mag_t              f_mag;
  logic [LEN2_W-1:0] f_len2;
  logic              s_rdy, s_vld;
  mag_t              s_mag;
  logic [ROOT_W-1:0] s_root;
  logic              d_rdy, d_vld;
  logic [2:0][Q_W-1:0] d_q;
  logic              out_en;
  logic [2:0][COLOR_W-1:0] color;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  crdc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .width    (image_width),
    .height   (image_height),
    .in_vld   (in_valid),
    .in_rdy   (f_rdy),
    .row      (pixel_row),
    .col      (pixel_col),
    .out_vld  (f_vld),
    .out_rdy  (s_rdy),
    .out_mag  (f_mag),
    .out_len2 (f_len2)
  );

  crdc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (f_vld),
    .in_rdy   (s_rdy),
    .in_mag   (f_mag),
    .in_len2  (f_len2),
    .out_vld  (s_vld),
    .out_rdy  (d_rdy),
    .out_mag  (s_mag),
    .out_root (s_root)
  );

  crdc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (s_vld),
    .in_rdy  (d_rdy),
    .in_mag  (s_mag),
    .in_root (s_root),
    .out_vld (d_vld),
    .out_rdy (out_en),
    .out_q   (d_q)
  );

  assign in_stall = !f_rdy;
  assign out_en   = !out_valid || !out_stall;

  genvar j;
  generate
    for (j = 0; j < 3; j++) begin : g_color
      logic [Q_W-1:0] u;
      logic [P_W-1:0] prod;

      // saturate at one, then u*255 as u*256 - u
      assign u = (d_q[j] > (Q_W'(1) << FRAC_BITS)) ? (Q_W'(1) << FRAC_BITS) : d_q[j];
      assign prod = {u, {COLOR_W{1'b0}}} - {{COLOR_W{1'b0}}, u};
      assign color[j] = prod[FRAC_BITS +: COLOR_W];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      red   <= color[0];
      green <= color[1];
      blue  <= color[2];
    end
  end

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input held while output side can move");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule
